// ===== hw/rtl/pwo_pkg.sv =====
// ----------------------------------------------------------------------------
// pwo_pkg: shared types and constants
// Command codes, register map, sizes and the front-to-back transfer record of
// the wavetable oscillator.
// ----------------------------------------------------------------------------
package pwo_pkg;

	// block sizes, fixed by the port widths
	localparam int VOICES          = 8;
	localparam int TABLE_LEN       = 1024;
	localparam int PHASE_FRAC_BITS = 16;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_VOICE = 2'd1,
		CMD_TABLE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [11:0] SAMPLE_MAX       = 12'd4095;
	localparam logic [31:0] STEP_SCALE_RESET = 32'd91625968;
	localparam logic [0:0]  REG_STEP_SCALE   = 1'd0;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_VOICE = 2'd1,
		OP_TABLE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_VOICE = 2'd1,
		BK_DRAIN = 2'd2,
		BK_DIV   = 2'd3
	} bk_state_t;

endpackage

// ===== hw/rtl/poly_wavetable_oscillator.sv =====
// ----------------------------------------------------------------------------
// poly_wavetable_oscillator: polyphonic wavetable oscillator
// Voice/table commands and sample ticks in, one mixed sample per tick out.
// ----------------------------------------------------------------------------
// A tick leaves the queue, the voices are issued one per cycle through a shared
// step/interpolate unit, that pipeline drains, and the bit-serial averaging
// divider then forms the sample. Voice and table commands are carried out as
// they leave the queue. A four-entry queue behind the input lets commands
// arrive while a tick is being mixed, and the output register holds a finished
// sample while the next commands are taken. The wavetable is not cleared by
// reset: words never written read as garbage.
module poly_wavetable_oscillator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [2:0]  voice,
	input  logic        gate,
	input  logic [23:0] freq,
	input  logic [15:0] fm,
	input  logic [15:0] am,
	input  logic [9:0]  table_addr,
	input  logic [15:0] table_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] sample,
	output logic [3:0]  active_voices
);
	logic [31:0]  step_scale_q;
	logic         q_valid, q_pop, q_gate;
	pwo_pkg::op_t q_op;
	logic [2:0]   q_voice;
	logic [23:0]  q_freq;
	logic [15:0]  q_fm, q_am, q_data;
	logic [9:0]   q_addr;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[1:1] == pwo_pkg::REG_STEP_SCALE) ? step_scale_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_scale_q <= pwo_pkg::STEP_SCALE_RESET;
		end else if (psel && penable && pwrite && paddr[1:1] == pwo_pkg::REG_STEP_SCALE) begin
			step_scale_q <= pwdata;
		end
	end

	pwo_front #(.DEPTH(4)) u_front (
		.clk (clk), .arst_n (arst_n),
		.in_valid (in_valid), .in_stall (in_stall),
		.cmd (cmd), .voice (voice), .gate (gate), .freq (freq), .fm (fm), .am (am),
		.table_addr (table_addr), .table_data (table_data),
		.q_valid (q_valid), .q_pop (q_pop), .q_op (q_op), .q_voice (q_voice),
		.q_gate (q_gate), .q_freq (q_freq), .q_fm (q_fm), .q_am (q_am),
		.q_addr (q_addr), .q_data (q_data)
	);

	pwo_back u_back (
		.clk (clk), .arst_n (arst_n), .step_scale (step_scale_q),
		.q_valid (q_valid), .q_pop (q_pop), .q_op (q_op), .q_voice (q_voice),
		.q_gate (q_gate), .q_freq (q_freq), .q_fm (q_fm), .q_am (q_am),
		.q_addr (q_addr), .q_data (q_data),
		.out_valid (out_valid), .out_stall (out_stall),
		.sample (sample), .active_voices (active_voices)
	);
endmodule

// ===== hw/rtl/pwo_front.sv =====
// ----------------------------------------------------------------------------
// pwo_front: command intake
// Accepts input transfers, drops commands that do nothing and pushes the
// rest into a small queue toward the voice engine.
// ----------------------------------------------------------------------------
module pwo_front #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [2:0]  voice,
	input  logic        gate,
	input  logic [23:0] freq,
	input  logic [15:0] fm,
	input  logic [15:0] am,
	input  logic [9:0]  table_addr,
	input  logic [15:0] table_data,
	output logic        q_valid,
	input  logic        q_pop,
	output pwo_pkg::op_t q_op,
	output logic [2:0]  q_voice,
	output logic        q_gate,
	output logic [23:0] q_freq,
	output logic [15:0] q_fm,
	output logic [15:0] q_am,
	output logic [9:0]  q_addr,
	output logic [15:0] q_data
);
	localparam int VOICES = pwo_pkg::VOICES;
	localparam int TABLE_LEN = pwo_pkg::TABLE_LEN;
	localparam int AW = $clog2(DEPTH);
	localparam int W = 2 + 3 + 1 + 24 + 16 + 16 + 10 + 16;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          keep, push, pop;
	pwo_pkg::op_t  op;
	logic [W-1:0]  rd_word;

	assign in_stall = (cnt_q == (AW+1)'(DEPTH));

	// classify: drop unknown commands and out-of-range indexes
	always_comb begin
		keep = 1'b0;
		op = pwo_pkg::OP_TICK;
		unique case (pwo_pkg::cmd_t'(cmd))
			pwo_pkg::CMD_TICK: begin
				keep = 1'b1;
			end
			pwo_pkg::CMD_VOICE: begin
				keep = (32'(voice) < VOICES);
				op = pwo_pkg::OP_VOICE;
			end
			pwo_pkg::CMD_TABLE: begin
				keep = (32'(table_addr) < TABLE_LEN);
				op = pwo_pkg::OP_TABLE;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = in_valid && !in_stall && keep;
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= {op, voice, gate, freq, fm, am, table_addr, table_data};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (32'(wr_q) == DEPTH-1) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (32'(rd_q) == DEPTH-1) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rd_word = mem_q[rd_q];
	assign q_op = pwo_pkg::op_t'(rd_word[W-1 -: 2]);
	assign {q_voice, q_gate, q_freq, q_fm, q_am, q_addr, q_data} = rd_word[W-3:0];
endmodule

// ===== hw/rtl/pwo_div.sv =====
// ----------------------------------------------------------------------------
// pwo_div: restoring divider
// Divides the weighted sum by count<<16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwo_div #(
	parameter int NW = 40,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW+1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign done = busy_q && (cnt_q == '0);
	assign quo = quo_q;

	// one shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q && cnt_q != '0) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== hw/rtl/pwo_back.sv =====
// ----------------------------------------------------------------------------
// pwo_back: voice engine
// Carries out queued commands; on a tick walks the voices one per cycle
// through a four-stage step/interpolate pipeline, then averages the mix.
// ----------------------------------------------------------------------------
module pwo_back (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] step_scale,
	input  logic        q_valid,
	output logic        q_pop,
	input  pwo_pkg::op_t q_op,
	input  logic [2:0]  q_voice,
	input  logic        q_gate,
	input  logic [23:0] q_freq,
	input  logic [15:0] q_fm,
	input  logic [15:0] q_am,
	input  logic [9:0]  q_addr,
	input  logic [15:0] q_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] sample,
	output logic [3:0]  active_voices
);
	localparam int VOICES = pwo_pkg::VOICES;
	localparam int TABLE_LEN = pwo_pkg::TABLE_LEN;
	localparam int PHASE_FRAC_BITS = pwo_pkg::PHASE_FRAC_BITS;
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES+1);
	localparam int TW = $clog2(TABLE_LEN);
	localparam int PW = TW + PHASE_FRAC_BITS + 1;
	localparam int SH = 39 - PHASE_FRAC_BITS;
	localparam logic [PW-1:0] SPAN = PW'(TABLE_LEN) << PHASE_FRAC_BITS;
	localparam int AW = 28 + CW;
	localparam int DW = CW + 16;
	localparam int QW = AW;

	logic [PW-2:0] phase_q [VOICES];
	logic [23:0]   vfreq_q [VOICES];
	logic [VOICES-1:0] gate_q;
	logic [15:0]   tbl_q [TABLE_LEN];

	pwo_pkg::bk_state_t st_q, st_d;
	logic [VW:0]   idx_q;
	logic [15:0]   fm_q, am_q;
	logic [AW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] quo;
	logic          out_full_q;
	logic [11:0]   sample_q;
	logic [3:0]    av_q;

	// stage 1: freq * (1 + fm), table reads
	logic          v_s1;
	logic [VW-1:0] k_s1;
	logic [39:0]   p_s1;
	logic [15:0]   y0_s1, y1_s1;
	logic [PHASE_FRAC_BITS-1:0] f_s1;
	// stage 2: scaled partial products, interpolation product
	logic          v_s2;
	logic [VW-1:0] k_s2;
	logic [55:0]   lo_s2, hi_s2;
	logic [15:0]   y0_s2;
	logic          dn_s2;
	logic [PHASE_FRAC_BITS+15:0] d_s2;
	// stage 3: step, clamped value
	logic          v_s3;
	logic [VW-1:0] k_s3;
	logic [PW-1:0] step_s3;
	logic [11:0]   val_s3;
	// stage 4: weighted value
	logic          v_s4;
	logic [27:0]   w_s4;

	logic          issue;
	logic [VW-1:0] ik;
	logic [TW-1:0] ii, ij;
	logic          pipe_busy;

	assign ik = idx_q[VW-1:0];
	assign issue = (st_q == pwo_pkg::BK_VOICE) && gate_q[ik];
	assign ii = phase_q[ik][PW-2 -: TW];
	assign ij = (32'(ii) == TABLE_LEN-1) ? '0 : ii + 1'b1;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

	// control sequencer
	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		div_start = 1'b0;
		unique case (st_q)
			pwo_pkg::BK_IDLE: begin
				if (q_valid) begin
					if (q_op == pwo_pkg::OP_TICK) begin
						if (!out_full_q) begin
							q_pop = 1'b1;
							st_d = pwo_pkg::BK_VOICE;
						end
					end else begin
						q_pop = 1'b1;
					end
				end
			end
			pwo_pkg::BK_VOICE: begin
				if (32'(idx_q) == VOICES-1)
					st_d = pwo_pkg::BK_DRAIN;
			end
			pwo_pkg::BK_DRAIN: begin
				if (!pipe_busy) begin
					div_start = 1'b1;
					st_d = pwo_pkg::BK_DIV;
				end
			end
			pwo_pkg::BK_DIV: begin
				if (div_done)
					st_d = pwo_pkg::BK_IDLE;
			end
			default: st_d = pwo_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pwo_pkg::BK_IDLE;
			idx_q <= '0;
			gate_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_full_q <= 1'b0;
			for (int k = 0; k < VOICES; k++) begin
				phase_q[k] <= '0;
				vfreq_q[k] <= '0;
			end
		end else begin
			st_q <= st_d;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (st_q == pwo_pkg::BK_VOICE)
				idx_q <= idx_q + 1'b1;
			else
				idx_q <= '0;
			// voice settings
			if (q_pop && q_op == pwo_pkg::OP_VOICE) begin
				gate_q[q_voice[VW-1:0]] <= q_gate;
				vfreq_q[q_voice[VW-1:0]] <= q_freq;
			end
			// phase advance with single wrap
			if (v_s3) begin
				phase_q[k_s3] <= ((PW'(phase_q[k_s3]) + step_s3) >= SPAN)
					? (PW-1)'(PW'(phase_q[k_s3]) + step_s3 - SPAN)
					: (PW-1)'(PW'(phase_q[k_s3]) + step_s3);
			end
			// output register
			if (div_done)
				out_full_q <= 1'b1;
			else if (out_valid && !out_stall)
				out_full_q <= 1'b0;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (q_pop && q_op == pwo_pkg::OP_TABLE)
			tbl_q[q_addr[TW-1:0]] <= q_data;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop && q_op == pwo_pkg::OP_TICK) begin
			fm_q <= q_fm;
			am_q <= q_am;
			acc_q <= '0;
			cnt_q <= '0;
		end
		k_s1 <= ik;
		p_s1 <= 40'(vfreq_q[ik]) * 40'(fm_q ^ 16'h8000);
		y0_s1 <= tbl_q[ii];
		y1_s1 <= tbl_q[ij];
		f_s1 <= phase_q[ik][PHASE_FRAC_BITS-1:0];

		k_s2 <= k_s1;
		lo_s2 <= 56'(p_s1) * 56'(step_scale[15:0]);
		hi_s2 <= 56'(p_s1) * 56'(step_scale[31:16]);
		y0_s2 <= y0_s1;
		dn_s2 <= (y1_s1 < y0_s1);
		d_s2 <= (y1_s1 >= y0_s1)
			? (PHASE_FRAC_BITS+16)'(y1_s1 - y0_s1) * (PHASE_FRAC_BITS+16)'(f_s1)
			: (PHASE_FRAC_BITS+16)'(y0_s1 - y1_s1) * (PHASE_FRAC_BITS+16)'(f_s1);

		k_s3 <= k_s2;
		begin
			logic [56:0] s;
			logic [16:0] dv;
			logic [16:0] v;
			s = (57'(hi_s2) + 57'(lo_s2 >> 16)) >> SH;
			step_s3 <= (s > 57'(SPAN)) ? SPAN : PW'(s);
			if (dn_s2) begin
				dv = 17'((d_s2 + (PHASE_FRAC_BITS+16)'({PHASE_FRAC_BITS{1'b1}}))
					>> PHASE_FRAC_BITS);
				v = 17'(y0_s2) - dv;
			end else begin
				v = 17'(y0_s2) + 17'(d_s2 >> PHASE_FRAC_BITS);
			end
			val_s3 <= (v > 17'(pwo_pkg::SAMPLE_MAX)) ? pwo_pkg::SAMPLE_MAX : v[11:0];
		end

		w_s4 <= 28'(val_s3) * 28'(am_q);
		if (v_s3)
			cnt_q <= cnt_q + 1'b1;
		if (v_s4)
			acc_q <= acc_q + AW'(w_s4);

		if (div_done) begin
			sample_q <= (cnt_q == '0) ? 12'd0
				: (quo > QW'(pwo_pkg::SAMPLE_MAX)) ? pwo_pkg::SAMPLE_MAX : quo[11:0];
			av_q <= 4'(cnt_q);
		end
	end

	pwo_div #(.NW(QW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    ({cnt_q, 16'd0}),
		.done   (div_done),
		.quo    (quo)
	);

	assign out_valid = out_full_q;
	assign sample = sample_q;
	assign active_voices = av_q;
endmodule

// ===== bench/tb_poly_wavetable_oscillator.sv =====
// ----------------------------------------------------------------------------
// tb_poly_wavetable_oscillator: self-checking bench for the wavetable oscillator
// Fills the wavetable, runs a directed table of commands, then random command
// streams under several step_scale settings. A local voice/phase model
// predicts each tick's mixed sample, unless a directed row gives its own, and
// every output transfer is checked in order against it.
// ----------------------------------------------------------------------------
module tb_poly_wavetable_oscillator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NVOICE   = 8;
	localparam int TLEN     = 1024;
	localparam int FRAC     = 16;
	localparam int LIMIT    = 600000;
	localparam int DRAIN_WAIT = 80;

	typedef struct {
		pwo_pkg::cmd_t cmd;
		logic [2:0]  voice;
		logic        gate;
		logic [23:0] freq;
		logic [15:0] fm;
		logic [15:0] am;
		logic [9:0]  table_addr;
		logic [15:0] table_data;
	} osc_cmd_t;

	typedef struct {
		osc_cmd_t    c;
		bit          typed;
		logic [11:0] smp;
		logic [3:0]  nact;
	} row_t;

	typedef struct {
		logic [11:0] smp;
		logic [3:0]  nact;
	} mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = '0;
	logic [2:0]  voice = '0;
	logic        gate = 1'b0;
	logic [23:0] freq = '0;
	logic [15:0] fm = '0, am = '0;
	logic [9:0]  table_addr = '0;
	logic [15:0] table_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] sample;
	logic [3:0]  active_voices;

	poly_wavetable_oscillator dut (.*);

	always #5 clk = ~clk;

	// model state
	logic [31:0] scale_q;
	logic [63:0] phase_q [NVOICE];
	logic [23:0] freq_q [NVOICE];
	logic        gate_q [NVOICE];
	logic [15:0] wave_q [TLEN];
	mix_t        mix_q [$];

	int  errors = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;
	int  hold_left = 0;

	// phase increment for one voice
	function automatic logic [63:0] phase_inc(logic [23:0] f, logic [15:0] fmv);
		logic [63:0] onepfm, p, s;
		logic [71:0] prod;
		onepfm = {48'd0, fmv ^ 16'h8000};
		p = {40'd0, f} * onepfm;
		prod = {8'd0, p} * {40'd0, scale_q};
		s = 64'(prod[71:39]);
		if (s > (64'd1 << 26))
			s = 64'd1 << 26;
		return s;
	endfunction

	// linear interpolation of the table at a phase
	function automatic logic [63:0] wave_at(logic [63:0] ph);
		logic [63:0] i, j, f, y0, y1, v, d;
		i = ph >> FRAC;
		if (i >= TLEN)
			i = '0;
		j = i + 64'd1;
		if (j >= TLEN)
			j = '0;
		f = ph & 64'hFFFF;
		y0 = 64'(wave_q[i]);
		y1 = 64'(wave_q[j]);
		if (y1 >= y0) begin
			v = y0 + (((y1 - y0) * f) >> FRAC);
		end else begin
			d = (y0 - y1) * f;
			v = y0 - ((d + 64'hFFFF) >> FRAC);
		end
		return (v > 4095) ? 64'd4095 : v;
	endfunction

	// update voice state for one command, returns 1 with the mix on a tick
	function automatic bit mix_predict(osc_cmd_t c, output mix_t m);
		logic [63:0] acc, ph, n, q;
		acc = '0;
		n = '0;
		m.smp = '0;
		m.nact = '0;
		case (c.cmd)
			pwo_pkg::CMD_VOICE: begin
				gate_q[c.voice] = c.gate;
				freq_q[c.voice] = c.freq;
				return 0;
			end
			pwo_pkg::CMD_TABLE: begin
				wave_q[c.table_addr] = c.table_data;
				return 0;
			end
			pwo_pkg::CMD_TICK: begin
				for (int k = 0; k < NVOICE; k++) begin
					if (gate_q[k]) begin
						n++;
						ph = phase_q[k];
						acc += wave_at(ph) * {48'd0, c.am};
						ph += phase_inc(freq_q[k], c.fm);
						if (ph >= (64'd1 << 26))
							ph -= (64'd1 << 26);
						phase_q[k] = ph;
					end
				end
				q = (n != 0) ? acc / (n << 16) : 64'd0;
				m.smp = (q > 4095) ? pwo_pkg::SAMPLE_MAX : q[11:0];
				m.nact = n[3:0];
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic note_mismatch(string what, int expd, int got);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, expd, got);
	endtask

	// one input transfer; returns at the accepting edge
	task automatic send_cmd(row_t r);
		mix_t m;
		bit   has;
		in_valid <= 1'b1;
		cmd <= r.c.cmd;
		voice <= r.c.voice;
		gate <= r.c.gate;
		freq <= r.c.freq;
		fm <= r.c.fm;
		am <= r.c.am;
		table_addr <= r.c.table_addr;
		table_data <= r.c.table_data;
		do @(posedge clk); while (in_stall);
		has = mix_predict(r.c, m);
		if (has) begin
			if (r.typed) begin
				m.smp = r.smp;
				m.nact = r.nact;
			end
			mix_q.push_back(m);
		end
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(99) < 12)
			pause(1);
	endtask

	task automatic drain();
		pause(1);
		while (mix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_scale(logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {pwo_pkg::REG_STEP_SCALE, 1'b0};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		scale_q = val;
	endtask

	function automatic row_t rand_row();
		row_t r;
		int   sel;
		sel = $urandom_range(99);
		r.typed = 1'b0;
		r.smp = '0;
		r.nact = '0;
		r.c.voice = 3'($urandom_range(7));
		r.c.gate = ($urandom_range(3) != 0);
		r.c.freq = $urandom_range(1) ? 24'($urandom_range(0, 4000 * 256)) : 24'($urandom);
		r.c.fm = 16'($urandom);
		r.c.am = 16'($urandom);
		r.c.table_addr = 10'($urandom);
		r.c.table_data = $urandom_range(1) ? 16'($urandom_range(0, 4095)) : 16'($urandom);
		if (sel < 45)
			r.c.cmd = pwo_pkg::CMD_TICK;
		else if (sel < 75)
			r.c.cmd = pwo_pkg::CMD_VOICE;
		else if (sel < 95)
			r.c.cmd = pwo_pkg::CMD_TABLE;
		else
			r.c.cmd = pwo_pkg::CMD_NONE;
		return r;
	endfunction

	function automatic row_t mk(pwo_pkg::cmd_t c, int v, bit g, int f, int fmv, int amv,
			int a, int d, bit typed = 0, int s = 0, int n = 0);
		row_t r;
		r.c.cmd = c;
		r.c.voice = 3'(v);
		r.c.gate = g;
		r.c.freq = 24'(f);
		r.c.fm = 16'(fmv);
		r.c.am = 16'(amv);
		r.c.table_addr = 10'(a);
		r.c.table_data = 16'(d);
		r.typed = typed;
		r.smp = 12'(s);
		r.nact = 4'(n);
		return r;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall, with a forced long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 12);
			end
		end
	end

	// output transfer check
	always @(posedge clk) begin
		mix_t m;
		if (arst_n && out_valid && !out_stall) begin
			if (mix_q.size() == 0) begin
				note_mismatch("unexpected sample", -1, sample);
			end else begin
				m = mix_q.pop_front();
				if (sample !== m.smp)
					note_mismatch("sample", m.smp, sample);
				if (active_voices !== m.nact)
					note_mismatch("active_voices", m.nact, active_voices);
			end
		end
	end

	initial begin
		row_t        dir [$];
		logic [31:0] scales [5];
		scale_q = pwo_pkg::STEP_SCALE_RESET;
		for (int k = 0; k < NVOICE; k++) begin
			phase_q[k] = '0;
			freq_q[k] = '0;
			gate_q[k] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_scale(pwo_pkg::STEP_SCALE_RESET);
		@(posedge clk);

		// fill every table word so no tick reads an unwritten entry
		quiet = 1'b1;
		for (int a = 0; a < TLEN; a++) begin
			send_cmd(mk(pwo_pkg::CMD_TABLE, 0, 0, 0, 0, 0, a, $urandom_range(0, 5000)));
			maybe_gap();
		end
		quiet = 1'b0;

		// directed rows
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_NONE, 7, 1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
			10'h3FF, 16'hFFFF));
		dir.push_back(mk(pwo_pkg::CMD_TABLE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		dir.push_back(mk(pwo_pkg::CMD_TABLE, 0, 0, 0, 0, 0, 1, 0));
		dir.push_back(mk(pwo_pkg::CMD_TABLE, 0, 0, 0, 0, 0, 10'h3FF, 12345));
		dir.push_back(mk(pwo_pkg::CMD_VOICE, 0, 1, 0, 0, 0, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1, 4094, 1));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
		dir.push_back(mk(pwo_pkg::CMD_VOICE, 7, 1, 24'hFFFFFF, 0, 0, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 16'h8000, 16'hFFFF, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0));
		for (int v = 1; v < 7; v++)
			dir.push_back(mk(pwo_pkg::CMD_VOICE, v, 1, 440 * 256 * v, 0, 0, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 16'h1234, 16'hFFFF, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_VOICE, 3, 0, 24'hABCDEF, 0, 0, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 16'hC000, 16'h4000, 0, 0));
		dir.push_back(mk(pwo_pkg::CMD_TABLE, 0, 0, 0, 0, 0, 5, 4095));
		dir.push_back(mk(pwo_pkg::CMD_TICK, 0, 0, 0, 16'h7FFF, 16'hFFFF, 0, 0));
		foreach (dir[i]) begin
			send_cmd(dir[i]);
			maybe_gap();
		end
		drain();

		// random phases under several scale settings
		scales[0] = pwo_pkg::STEP_SCALE_RESET;
		scales[1] = 32'd0;
		scales[2] = 32'hFFFFFFFF;
		scales[3] = $urandom;
		scales[4] = $urandom_range(1, 32'h0800_0000);
		for (int p = 0; p < 5; p++) begin
			write_scale(scales[p]);
			quiet = (p == 0);
			if (p == 3)
				hold_left = 600;
			for (int n = 0; n < 140; n++) begin
				send_cmd(rand_row());
				maybe_gap();
			end
			quiet = 1'b0;
			drain();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
